// ===== design/kie_pkg.sv =====
// Shared types and constants for the infrared pulse encoder.
package kie_pkg;

  localparam int CMD_W = 48;
  localparam int DUR_W = 16;
  localparam int CFG_IDX_W = 3;

  // Codes below this value get the default prefix added.
  localparam logic [CMD_W-1:0] SHORT_LIMIT = 48'h0000_0100_0000;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PREFIX = 3'd5;

  localparam logic [DUR_W-1:0] RST_HEADER_MARK  = 16'd3550;
  localparam logic [DUR_W-1:0] RST_HEADER_SPACE = 16'd1650;
  localparam logic [DUR_W-1:0] RST_BIT_MARK     = 16'd497;
  localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd347;
  localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 16'd1218;
  localparam logic [CMD_W-1:0] RST_DEFAULT_PREFIX = 48'hBFFB_FA00_0000;

  typedef struct packed {
    logic [DUR_W-1:0] header_mark;
    logic [DUR_W-1:0] header_space;
    logic [DUR_W-1:0] bit_mark;
    logic [DUR_W-1:0] one_space;
    logic [DUR_W-1:0] zero_space;
  } timing_t;

endpackage

// ===== design/kaseikyo_ir_pulse_encoder.sv =====
// Top level: 48-bit infrared command to mark/space pulse train encoder.
// Path: with the block idle, an accepted command is queued, then its header pair is registered.
// Throughput: CODE_BITS + 2 pairs per command (50 by default), one pair per cycle while the
//   output is popped or empty; the back-end pair sequencer sets this, commands run back to back.
// Reset: asynchronous, active low; empties the command queue and the output register and
//   restores the timing registers and default prefix to their power-on values.
module kaseikyo_ir_pulse_encoder #(
  parameter int CODE_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command input, queue style
  input  logic                          push,
  output logic                          full,
  input  logic [kie_pkg::CMD_W-1:0]     command_code_i,
  // pulse pair output, queue style
  output logic                          empty,
  input  logic                          pop,
  output logic [kie_pkg::DUR_W-1:0]     mark_us_o,
  output logic [kie_pkg::DUR_W-1:0]     space_us_o,
  output logic                          checksum_fixed_o,
  output logic                          last_o,
  // register write port
  input  logic                          cfg_we_i,
  input  logic [kie_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kie_pkg::CMD_W-1:0]     cfg_data_i
);

  kie_pkg::timing_t           timing_q, timing_d;
  logic [kie_pkg::CMD_W-1:0]  prefix_q, prefix_d;

  logic [CODE_BITS-1:0]       fe_code;
  logic                       fe_fixed;
  logic                       q_valid;
  logic                       q_pop;
  logic [CODE_BITS:0]         q_data;

  // Register file: write only while the block is idle (the block itself does not enforce
  // this on its writes), so the sequencer and front end read these directly.
  always_comb begin
    timing_d = timing_q;
    prefix_d = prefix_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        kie_pkg::REG_HEADER_MARK:    timing_d.header_mark  = cfg_data_i[kie_pkg::DUR_W-1:0];
        kie_pkg::REG_HEADER_SPACE:   timing_d.header_space = cfg_data_i[kie_pkg::DUR_W-1:0];
        kie_pkg::REG_BIT_MARK:       timing_d.bit_mark     = cfg_data_i[kie_pkg::DUR_W-1:0];
        kie_pkg::REG_ONE_SPACE:      timing_d.one_space    = cfg_data_i[kie_pkg::DUR_W-1:0];
        kie_pkg::REG_ZERO_SPACE:     timing_d.zero_space   = cfg_data_i[kie_pkg::DUR_W-1:0];
        kie_pkg::REG_DEFAULT_PREFIX: prefix_d              = cfg_data_i;
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.header_mark  <= kie_pkg::RST_HEADER_MARK;
      timing_q.header_space <= kie_pkg::RST_HEADER_SPACE;
      timing_q.bit_mark     <= kie_pkg::RST_BIT_MARK;
      timing_q.one_space    <= kie_pkg::RST_ONE_SPACE;
      timing_q.zero_space   <= kie_pkg::RST_ZERO_SPACE;
      prefix_q              <= kie_pkg::RST_DEFAULT_PREFIX;
    end else begin
      timing_q <= timing_d;
      prefix_q <= prefix_d;
    end
  end

  // Front end: add the prefix to short codes and correct the checksum byte.
  kie_front #(
    .CODE_BITS(CODE_BITS)
  ) u_front (
    .command_code_i  (command_code_i),
    .default_prefix_i(prefix_q),
    .code_o          (fe_code),
    .fixed_o         (fe_fixed)
  );

  // Decoupling queue: full here is the input side's back-pressure.
  kie_queue #(
    .W(CODE_BITS + 1)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({fe_fixed, fe_code}),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  // Back end: header pair, one pair per code bit, closing pair.
  kie_back #(
    .CODE_BITS(CODE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .timing_i        (timing_q),
    .q_valid_i       (q_valid),
    .q_code_i        (q_data[CODE_BITS-1:0]),
    .q_fixed_i       (q_data[CODE_BITS]),
    .q_pop_o         (q_pop),
    .pop             (pop),
    .empty           (empty),
    .mark_us_o       (mark_us_o),
    .space_us_o      (space_us_o),
    .checksum_fixed_o(checksum_fixed_o),
    .last_o          (last_o)
  );

`ifndef SYNTHESIS
  // The closing pair always has a zero space.
  a_last_zero_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_o) |-> (space_us_o == '0))
    else $error("closing pair with nonzero space");

  // The correction flag rides on the header pair only, never on the closing pair.
  a_fixed_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(!empty && last_o && checksum_fixed_o))
    else $error("correction flag on closing pair");

  // The sequencer only takes a command that the queue holds.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // Taking a command from the queue always puts a header pair on the result port.
  a_pop_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> (!empty && !last_o && mark_us_o == timing_q.header_mark))
    else $error("command taken without a header pair");
`endif

endmodule

// ===== design/kie_front.sv =====
// Front end: prefix short codes and fix up the byte checksum.
module kie_front #(
  parameter int CODE_BITS = 48
) (
  input  logic [kie_pkg::CMD_W-1:0] command_code_i,
  input  logic [kie_pkg::CMD_W-1:0] default_prefix_i,
  output logic [CODE_BITS-1:0]      code_o,
  output logic                      fixed_o
);

  logic [kie_pkg::CMD_W-1:0] code_pre;
  logic [kie_pkg::CMD_W-1:0] code_fix;
  logic [7:0]                chk;

  always_comb begin
    if (command_code_i < kie_pkg::SHORT_LIMIT) begin
      code_pre = command_code_i + default_prefix_i;
    end else begin
      code_pre = command_code_i;
    end
    chk      = code_pre[7:0] ^ code_pre[15:8] ^ code_pre[23:16] ^ code_pre[31:24];
    code_fix = {code_pre[kie_pkg::CMD_W-1:8], code_pre[7:0] ^ chk};
    fixed_o  = (chk != 8'd0);
    code_o   = code_fix[CODE_BITS-1:0];
  end

endmodule

// ===== design/kie_queue.sv =====
// Two-entry queue between the front end and the pulse sequencer.
module kie_queue #(
  parameter int W = 49
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    do_push  = push_i && !full_o;
    do_pop   = pop_i && valid_o;
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/kie_back.sv =====
// Back end: sequence the mark/space pairs of one code into the output register.
module kie_back #(
  parameter int CODE_BITS = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kie_pkg::timing_t          timing_i,
  input  logic                      q_valid_i,
  input  logic [CODE_BITS-1:0]      q_code_i,
  input  logic                      q_fixed_i,
  output logic                      q_pop_o,
  input  logic                      pop,
  output logic                      empty,
  output logic [kie_pkg::DUR_W-1:0] mark_us_o,
  output logic [kie_pkg::DUR_W-1:0] space_us_o,
  output logic                      checksum_fixed_o,
  output logic                      last_o
);

  localparam int CNT_W = $clog2(CODE_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_BITS);

  logic                      busy_q, busy_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [CODE_BITS-1:0]      sh_q, sh_d;
  logic                      out_vld_q, out_vld_d;
  logic [kie_pkg::DUR_W-1:0] mark_q, mark_d;
  logic [kie_pkg::DUR_W-1:0] space_q, space_d;
  logic                      fixed_q, fixed_d;
  logic                      last_q, last_d;
  logic                      adv, produce;

  assign empty            = !out_vld_q;
  assign mark_us_o        = mark_q;
  assign space_us_o       = space_q;
  assign checksum_fixed_o = fixed_q;
  assign last_o           = last_q;

  always_comb begin
    adv       = !out_vld_q || pop;
    produce   = adv && (busy_q || q_valid_i);
    q_pop_o   = adv && !busy_q && q_valid_i;
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    sh_d      = sh_q;
    out_vld_d = out_vld_q;
    mark_d    = mark_q;
    space_d   = space_q;
    fixed_d   = fixed_q;
    last_d    = last_q;
    if (adv) begin
      out_vld_d = produce;
    end
    if (produce) begin
      if (!busy_q) begin
        // header pair, carries the correction flag
        busy_d  = 1'b1;
        cnt_d   = '0;
        sh_d    = q_code_i;
        mark_d  = timing_i.header_mark;
        space_d = timing_i.header_space;
        fixed_d = q_fixed_i;
        last_d  = 1'b0;
      end else if (cnt_q != CNT_LAST) begin
        mark_d  = timing_i.bit_mark;
        space_d = sh_q[CODE_BITS-1] ? timing_i.one_space : timing_i.zero_space;
        sh_d    = sh_q << 1;
        cnt_d   = cnt_q + CNT_W'(1);
        fixed_d = 1'b0;
        last_d  = 1'b0;
      end else begin
        mark_d  = timing_i.bit_mark;
        space_d = '0;
        fixed_d = 1'b0;
        last_d  = 1'b1;
        busy_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q    <= sh_d;
    mark_q  <= mark_d;
    space_q <= space_d;
    fixed_q <= fixed_d;
    last_q  <= last_d;
  end

endmodule
